@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include guarded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

@@ rtl/afm_pkg.sv @@
// Package for the alloc/free trace monitor: codes, result layout, tracker step.
// No dependencies.
`default_nettype none

package afm_pkg;

	localparam int unsigned ENTRIES_DEF   = 64;
	localparam int unsigned KEY_WIDTH_DEF = 64;

	localparam int unsigned KEY_FIELD_W = 64;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned INDEX_W     = 6;
	localparam int unsigned STATE_W     = 3;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned OUT_W       = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_FINISH  = 2'd2,
		CMD_ILLEGAL = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_HALTED  = 2'd1,
		STS_FULL    = 2'd2,
		STS_ILLEGAL = 2'd3
	} status_t;

	typedef enum logic [STATE_W-1:0] {
		TS_FRESH         = 3'd0,
		TS_ALLOC         = 3'd1,
		TS_FREED         = 3'd2,
		TS_FREE_NO_ALLOC = 3'd3,
		TS_DOUBLE_ALLOC  = 3'd4,
		TS_DOUBLE_FREE   = 3'd5
	} trk_state_t;

	// Result word, status in the lowest bits.
	typedef struct packed {
		logic                 halted;
		logic [COUNT_W-1:0]   cnt_double_free;
		logic [COUNT_W-1:0]   cnt_double_alloc;
		logic [COUNT_W-1:0]   cnt_free_no_alloc;
		logic [COUNT_W-1:0]   cnt_unfreed;
		trk_state_t           new_state;
		logic [INDEX_W-1:0]   entry_index;
		status_t              status;
	} result_t;

	function automatic trk_state_t next_state(trk_state_t cur, logic is_free);
		trk_state_t nxt;
		case (cur)
			TS_FRESH: nxt = is_free ? TS_FREE_NO_ALLOC : TS_ALLOC;
			TS_ALLOC: nxt = is_free ? TS_FREED : TS_DOUBLE_ALLOC;
			TS_FREED: nxt = is_free ? TS_DOUBLE_FREE : TS_ALLOC;
			default:  nxt = cur;
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

@@ rtl/alloc_free_trace_monitor_unit.sv @@
// Alloc/free trace monitor: key table and per-key tracker state in two memories.
// Depends on afm_pkg.
`default_nettype none

// Usage
//  Input channel s_axis: one transaction per event. tuser carries the command
//  (alloc, free, finish, illegal), tdata the 64-bit address key, of which the
//  low KEY_WIDTH bits are compared.
//  Output channel m_axis: exactly one result transaction per input event.
//  Flow from accept to result in the output register: alloc, free and
//  illegal events scan the key memory linearly, one slot per cycle through its
//  single read port with registered read, stopping at the matching key or at
//  the entry count. Finish, any event on an empty table and any event once
//  halted skip the scan. The engine returns to idle as the result is loaded
//  and then takes the next event.
//  Stall: a result waiting in the output register does not block intake of the
//  next event; the engine only holds in its final step until the register is
//  free, and no state is committed before that.
//  Reset: entry count, error counters, halt flag and handshakes clear at once;
//  the memories are not cleared, only slots below the entry count are used.
module alloc_free_trace_monitor_unit #(
	parameter int unsigned ENTRIES   = afm_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_WIDTH = afm_pkg::KEY_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire  [afm_pkg::KEY_FIELD_W-1:0] s_axis_tdata,  // [63:0] address_key
	input  wire  [afm_pkg::CMD_W-1:0]       s_axis_tuser,  // [1:0] cmd
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// [1:0] status, [7:2] entry_index, [10:8] new_state, [17:11] count_unfreed,
	// [24:18] count_free_no_alloc, [31:25] count_double_alloc,
	// [38:32] count_double_free, [39] is_halted
	output logic [afm_pkg::OUT_W-1:0]       m_axis_tdata
);

	localparam int unsigned IDXW = $clog2(ENTRIES);
	localparam int unsigned CNTW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		FSM_IDLE  = 3'b001,
		FSM_SCAN  = 3'b010,
		FSM_FINAL = 3'b100
	} fsm_t;

	// Storage: keys and tracker states, one read port each, registered read.
	logic [KEY_WIDTH-1:0]         key_mem [ENTRIES];
	logic [afm_pkg::STATE_W-1:0]  st_mem  [ENTRIES];

	fsm_t                         fsm_q;
	logic [CNTW-1:0]              count_q;     // slots in use
	logic [CNTW-1:0]              scan_q;      // next slot to read
	logic                         halted_q;
	logic [afm_pkg::COUNT_W-1:0]  c_unfreed_q, c_fna_q, c_da_q, c_df_q;

	// Event being worked on
	afm_pkg::cmd_t                cmd_q;
	logic [KEY_WIDTH-1:0]         key_q;
	logic                         found_q;
	logic [IDXW-1:0]              slot_q;
	afm_pkg::trk_state_t          cur_q;

	// Read pipeline
	logic                         vld_s1;
	logic [IDXW-1:0]              idx_s1;
	logic [KEY_WIDTH-1:0]         key_rd_s1;
	logic [afm_pkg::STATE_W-1:0]  st_rd_s1;

	// Output register
	logic                         out_vld_q;
	afm_pkg::result_t             out_q;

	logic                         in_acc;
	logic                         issuing;
	logic                         hit;
	logic                         out_free;
	logic                         commit;
	logic [IDXW-1:0]              rd_addr;

	afm_pkg::result_t             res;
	logic                         set_halt;
	logic                         upd;         // alloc/free step commits
	logic                         new_key;
	logic [IDXW-1:0]              wr_slot;
	afm_pkg::trk_state_t          st_old, st_new;

	function automatic logic [afm_pkg::COUNT_W-1:0] cnt_adj(
		logic [afm_pkg::COUNT_W-1:0] c,
		afm_pkg::trk_state_t         o,
		afm_pkg::trk_state_t         n,
		afm_pkg::trk_state_t         s
	);
		logic [afm_pkg::COUNT_W-1:0] r;
		r = c + afm_pkg::COUNT_W'(n == s) - afm_pkg::COUNT_W'(o == s);
		return r;
	endfunction

	assign s_axis_tready = (fsm_q == FSM_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign commit        = (fsm_q == FSM_FINAL) && out_free;

	assign issuing = (fsm_q == FSM_SCAN) && (scan_q < count_q);
	assign rd_addr = scan_q[IDXW-1:0];
	assign hit     = vld_s1 && (key_rd_s1 == key_q);

	// Final step: build result and the state updates.
	always_comb begin
		res      = '0;
		set_halt = 1'b0;
		upd      = 1'b0;
		new_key  = 1'b0;
		wr_slot  = found_q ? slot_q : count_q[IDXW-1:0];
		st_old   = found_q ? cur_q : afm_pkg::TS_FRESH;
		st_new   = afm_pkg::next_state(st_old, cmd_q == afm_pkg::CMD_FREE);
		if (halted_q) begin
			res.status = afm_pkg::STS_HALTED;
			res.halted = 1'b1;
		end else begin
			case (cmd_q)
				afm_pkg::CMD_FINISH: begin
					set_halt = 1'b1;
				end
				afm_pkg::CMD_ILLEGAL: begin
					if (found_q && (cur_q == afm_pkg::TS_FREE_NO_ALLOC ||
						cur_q == afm_pkg::TS_DOUBLE_ALLOC ||
						cur_q == afm_pkg::TS_DOUBLE_FREE)) begin
						// absorbing key: event ignored
						res.entry_index = afm_pkg::INDEX_W'(slot_q);
						res.new_state   = cur_q;
					end else begin
						set_halt   = 1'b1;
						res.status = afm_pkg::STS_ILLEGAL;
					end
				end
				default: begin
					if (!found_q && count_q == CNTW'(ENTRIES)) begin
						res.status = afm_pkg::STS_FULL;
					end else begin
						upd             = 1'b1;
						new_key         = !found_q;
						res.entry_index = afm_pkg::INDEX_W'(wr_slot);
						res.new_state   = st_new;
					end
				end
			endcase
			if (set_halt) begin
				res.halted            = 1'b1;
				res.cnt_unfreed       = c_unfreed_q;
				res.cnt_free_no_alloc = c_fna_q;
				res.cnt_double_alloc  = c_da_q;
				res.cnt_double_free   = c_df_q;
			end
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= FSM_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			halted_q    <= 1'b0;
			vld_s1      <= 1'b0;
			out_vld_q   <= 1'b0;
			found_q     <= 1'b0;
			c_unfreed_q <= '0;
			c_fna_q     <= '0;
			c_da_q      <= '0;
			c_df_q      <= '0;
		end else begin
			vld_s1 <= issuing;
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (fsm_q)
				FSM_IDLE: begin
					if (in_acc) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						if (halted_q || afm_pkg::cmd_t'(s_axis_tuser) == afm_pkg::CMD_FINISH ||
							count_q == '0) begin
							fsm_q <= FSM_FINAL;
						end else begin
							fsm_q <= FSM_SCAN;
						end
					end
				end
				FSM_SCAN: begin
					if (issuing) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						found_q <= 1'b1;
						fsm_q   <= FSM_FINAL;
					end else if (!issuing) begin
						fsm_q <= FSM_FINAL;
					end
				end
				FSM_FINAL: begin
					if (commit) begin
						fsm_q     <= FSM_IDLE;
						if (set_halt) begin
							halted_q <= 1'b1;
						end
						if (new_key) begin
							count_q <= count_q + 1'b1;
						end
						if (upd) begin
							c_unfreed_q <= cnt_adj(c_unfreed_q, st_old, st_new, afm_pkg::TS_ALLOC);
							c_fna_q     <= cnt_adj(c_fna_q, st_old, st_new,
								afm_pkg::TS_FREE_NO_ALLOC);
							c_da_q      <= cnt_adj(c_da_q, st_old, st_new,
								afm_pkg::TS_DOUBLE_ALLOC);
							c_df_q      <= cnt_adj(c_df_q, st_old, st_new,
								afm_pkg::TS_DOUBLE_FREE);
						end
					end
				end
				default: fsm_q <= FSM_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= afm_pkg::cmd_t'(s_axis_tuser);
			key_q <= s_axis_tdata[KEY_WIDTH-1:0];
		end
		idx_s1 <= rd_addr;
		if (fsm_q == FSM_SCAN && hit) begin
			slot_q <= idx_s1;
			cur_q  <= afm_pkg::trk_state_t'(st_rd_s1);
		end
		if (commit) begin
			out_q <= res;
		end
	end

	// Memories: read every cycle; commit writes new keys, alloc/free states.
	always_ff @(posedge clk) begin
		key_rd_s1 <= key_mem[rd_addr];
		st_rd_s1  <= st_mem[rd_addr];
		if (commit && new_key) begin
			key_mem[wr_slot] <= key_q;
		end
		if (commit && upd) begin
			st_mem[wr_slot] <= st_new;
		end
	end

endmodule

`default_nettype wire

@@ rtl/afm_checker.sv @@
// Port-level checker for the alloc/free trace monitor, bound to the top level.
// Depends on afm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module afm_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_axis_tvalid,
	input wire                             s_axis_tready,
	input wire [afm_pkg::KEY_FIELD_W-1:0]  s_axis_tdata,
	input wire [afm_pkg::CMD_W-1:0]        s_axis_tuser,
	input wire                             m_axis_tvalid,
	input wire                             m_axis_tready,
	input wire [afm_pkg::OUT_W-1:0]        m_axis_tdata
);

	logic [1:0]        pend_q;    // events in flight
	logic              seen_halt_q;
	logic              in_acc, out_acc;
	logic              cnt_zero;
	afm_pkg::result_t  res;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_acc  = m_axis_tvalid && m_axis_tready;
	assign res      = afm_pkg::result_t'(m_axis_tdata);
	assign cnt_zero = (res.cnt_unfreed == '0) && (res.cnt_free_no_alloc == '0) &&
		(res.cnt_double_alloc == '0) && (res.cnt_double_free == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_halt_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc && res.halted) begin
				seen_halt_q <= 1'b1;
			end
		end
	end

	`AST_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`AST_NOW(a_no_orphan, clk, arst_n, m_axis_tvalid, pend_q != 2'd0 && pend_q != 2'd3)
	`AST_NOW(a_halt_sticky, clk, arst_n, m_axis_tvalid && seen_halt_q, res.status == afm_pkg::STS_HALTED && res.halted)
	`AST_NOW(a_ok_clean, clk, arst_n, m_axis_tvalid && !res.halted, (res.status == afm_pkg::STS_OK || res.status == afm_pkg::STS_FULL) && cnt_zero)

	// s_axis_tdata and s_axis_tuser are visible for waveform debug only
	logic unused_in;
	assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind alloc_free_trace_monitor_unit afm_checker u_afm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
